// ===== design/tpa_pkg.sv =====
// Shared constants, types and the square-root digit step for the triangle block.
`timescale 1ns / 1ps
package tpa_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int D2_W    = 2 * COORD_BITS + 4;

	localparam int ROOT_W    = (D2_W + 2 * FRAC_BITS) / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int SQ_STAGES = (ROOT_W + 1) / 2;
	localparam int RAD_W     = 4 * SQ_STAGES;

	localparam int PERIM_W = 27;
	localparam int AREA_W  = 32;

	localparam int FRONT_LAT = 4;
	localparam int CORE_LAT  = FRONT_LAT + SQ_STAGES;

	localparam int IN_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((PERIM_W + AREA_W + 7) / 8) * 8;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] by_coord;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] ax;
	} coords_t;

	typedef struct packed {
		logic [D2_W-1:0]   d2_ab;
		logic [D2_W-1:0]   d2_bc;
		logic [D2_W-1:0]   d2_ca;
		logic [AREA_W-1:0] area;
	} front_out_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
	} sq_state_t;

	// one restoring digit of the integer square root
	function automatic sq_state_t sq_step(input sq_state_t st, input logic [1:0] pair);
		logic [REM_W-1:0] rem_t;
		logic [REM_W-1:0] trial;
		sq_state_t r;
		rem_t = {st.rem[REM_W-3:0], pair};
		trial = {1'b0, st.root, 2'b01};
		if (rem_t >= trial) begin
			r.rem  = rem_t - trial;
			r.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem_t;
			r.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== design/tpa_front.sv =====
// Front pipeline: edge vectors, squares, cross products, squared lengths and |cross|.
`timescale 1ns / 1ps
module tpa_front (
	input  logic                clk,
	input  logic                en,
	input  tpa_pkg::coords_t    crd,
	output tpa_pkg::front_out_t fo
);
	import tpa_pkg::*;

	// stage 1: edge differences
	logic signed [DIFF_W-1:0] dx_ab_s1, dy_ab_s1, dx_bc_s1, dy_bc_s1, dx_ca_s1, dy_ca_s1;
	// stage 2: products
	logic signed [PROD_W-1:0] sx_ab_s2, sy_ab_s2, sx_bc_s2, sy_bc_s2, sx_ca_s2, sy_ca_s2;
	logic signed [PROD_W-1:0] xp1_s2, xp2_s2;
	// stage 3: sums
	logic [D2_W-1:0]           d2_ab_s3, d2_bc_s3, d2_ca_s3;
	logic signed [CROSS_W-1:0] cross_s3;
	// stage 4: magnitude
	logic [D2_W-1:0]   d2_ab_s4, d2_bc_s4, d2_ca_s4;
	logic [AREA_W-1:0] area_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_ab_s1 <= DIFF_W'(crd.ax) - DIFF_W'(crd.bx);
			dy_ab_s1 <= DIFF_W'(crd.ay) - DIFF_W'(crd.by_coord);
			dx_bc_s1 <= DIFF_W'(crd.bx) - DIFF_W'(crd.cx);
			dy_bc_s1 <= DIFF_W'(crd.by_coord) - DIFF_W'(crd.cy);
			dx_ca_s1 <= DIFF_W'(crd.cx) - DIFF_W'(crd.ax);
			dy_ca_s1 <= DIFF_W'(crd.cy) - DIFF_W'(crd.ay);

			sx_ab_s2 <= dx_ab_s1 * dx_ab_s1;
			sy_ab_s2 <= dy_ab_s1 * dy_ab_s1;
			sx_bc_s2 <= dx_bc_s1 * dx_bc_s1;
			sy_bc_s2 <= dy_bc_s1 * dy_bc_s1;
			sx_ca_s2 <= dx_ca_s1 * dx_ca_s1;
			sy_ca_s2 <= dy_ca_s1 * dy_ca_s1;
			// (b-a) x (c-a) rewritten on the edge differences
			xp1_s2   <= dy_ab_s1 * dx_ca_s1;
			xp2_s2   <= dx_ab_s1 * dy_ca_s1;

			d2_ab_s3 <= D2_W'(sx_ab_s2) + D2_W'(sy_ab_s2);
			d2_bc_s3 <= D2_W'(sx_bc_s2) + D2_W'(sy_bc_s2);
			d2_ca_s3 <= D2_W'(sx_ca_s2) + D2_W'(sy_ca_s2);
			cross_s3 <= CROSS_W'(xp1_s2) - CROSS_W'(xp2_s2);

			d2_ab_s4 <= d2_ab_s3;
			d2_bc_s4 <= d2_bc_s3;
			d2_ca_s4 <= d2_ca_s3;
			area_s4  <= cross_s3[CROSS_W-1] ? AREA_W'(-cross_s3) : AREA_W'(cross_s3);
		end
	end

	assign fo.d2_ab = d2_ab_s4;
	assign fo.d2_bc = d2_bc_s4;
	assign fo.d2_ca = d2_ca_s4;
	assign fo.area  = area_s4;

endmodule

// ===== design/tpa_sqrt.sv =====
// Pipelined integer square root of d2 scaled by 2^(2*FRAC_BITS), two digits per stage.
`timescale 1ns / 1ps
module tpa_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tpa_pkg::D2_W-1:0]   d2,
	output logic [tpa_pkg::ROOT_W-1:0] root
);
	import tpa_pkg::*;

	sq_state_t        st_s  [SQ_STAGES];
	logic [RAD_W-1:0] rad_s [SQ_STAGES];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		sq_state_t        st_in, st_mid, st_out;
		logic [RAD_W-1:0] rad_in;

		if (g == 0) begin : g_first
			assign st_in  = '0;
			assign rad_in = RAD_W'(d2) << (2 * FRAC_BITS);
		end else begin : g_next
			assign st_in  = st_s[g-1];
			assign rad_in = rad_s[g-1];
		end

		assign st_mid = sq_step(st_in, rad_in[RAD_W-1 -: 2]);
		assign st_out = sq_step(st_mid, rad_in[RAD_W-3 -: 2]);

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g]  <= st_out;
				rad_s[g] <= rad_in << 4;
			end
		end
	end

	assign root = st_s[SQ_STAGES-1].root;

endmodule

// ===== design/triangle_perimeter_area_top.sv =====
// Pipeline: 4 front stages, 13 root stages and 1 output stage from input beat to output beat.
// Throughput: one triangle per cycle while the output is not stalled; each of the three side roots runs in a
// 13-stage pipeline resolving two root digits per stage.
// A stall on the output holds the whole pipeline in place.
// Reset clears only the valid bits; data registers are not reset.
`timescale 1ns / 1ps
module triangle_perimeter_area_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// ax, ay, bx, by_coord, cx, cy (16 bits each)
	input  logic [tpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// perimeter_q8 [26:0], double_area [58:27], zero pad
	output logic [tpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import tpa_pkg::*;

	logic              en;
	coords_t           crd;
	front_out_t        fo;
	logic [ROOT_W-1:0] root_ab, root_bc, root_ca;

	logic [CORE_LAT-1:0] vld_s;
	logic [AREA_W-1:0]   area_s [SQ_STAGES];
	logic                out_vld_q;
	logic [PERIM_W-1:0]  perim_q;
	logic [AREA_W-1:0]   area_q;

	// pipeline moves unless the output beat is stuck
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	assign crd.ax       = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
	assign crd.ay       = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
	assign crd.bx       = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
	assign crd.by_coord = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
	assign crd.cx       = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
	assign crd.cy       = s_axis_tdata[5*COORD_BITS +: COORD_BITS];

	tpa_front u_front (
		.clk (clk),
		.en  (en),
		.crd (crd),
		.fo  (fo)
	);

	tpa_sqrt u_sqrt_ab (.clk(clk), .en(en), .d2(fo.d2_ab), .root(root_ab));
	tpa_sqrt u_sqrt_bc (.clk(clk), .en(en), .d2(fo.d2_bc), .root(root_bc));
	tpa_sqrt u_sqrt_ca (.clk(clk), .en(en), .d2(fo.d2_ca), .root(root_ca));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[CORE_LAT-2:0], s_axis_tvalid};
			out_vld_q <= vld_s[CORE_LAT-1];
		end
	end

	// area rides alongside the root pipelines
	always_ff @(posedge clk) begin
		if (en) begin
			area_s[0] <= fo.area;
			for (int i = 1; i < SQ_STAGES; i++) begin
				area_s[i] <= area_s[i-1];
			end
			perim_q <= PERIM_W'(32'(root_ab) + 32'(root_bc) + 32'(root_ca));
			area_q  <= area_s[SQ_STAGES-1];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'({area_q, perim_q});

endmodule

// ===== test/tb_triangle_perimeter_area_top.sv =====
// Self-checking stream testbench for the triangle perimeter and area block.
`timescale 1ns / 1ps
module tb_triangle_perimeter_area_top;
	import tpa_pkg::*;

	localparam int N_DIRECTED = 19;
	localparam int N_RANDOM   = 1531;
	localparam int PRESS_AT   = 300;
	localparam int PRESS_LEN  = 250;

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [PERIM_W-1:0] perim;
	} tri_result_t;

	typedef struct packed {
		int          ax;
		int          ay;
		int          bx;
		int          by_c;
		int          cx;
		int          cy;
		bit          known;
		int unsigned perim;
		int unsigned area;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	tri_result_t expected_q[$];
	int          err_cnt = 0;
	int          accepted_cnt = 0;
	int          ready_stall = 0;
	int          ready_cyc = 0;
	bit          press_done = 1'b0;

	// known answers: right triangles, coincident and extreme vertices
	dir_row_t directed_rows [N_DIRECTED] = '{
		'{0, 0, 0, 0, 0, 0, 1'b1, 0, 0},
		'{0, 0, 3, 0, 0, 4, 1'b1, 3072, 12},
		'{0, 0, 1, 0, 0, 1, 1'b1, 874, 1},
		'{-32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 0, 0},
		'{32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 0, 0},
		'{-32768, -32768, 32767, -32768, -32768, 32767, 1'b0, 0, 0},
		'{32767, 32767, -32768, -32768, 32767, -32768, 1'b0, 0, 0},
		'{1, 1, 2, 2, 3, 3, 1'b0, 0, 0},
		'{-5, 7, -5, 7, 10, -3, 1'b0, 0, 0},
		'{-32768, 0, 0, 0, 0, 0, 1'b0, 0, 0},
		'{0, -32768, 0, 0, 0, 0, 1'b0, 0, 0},
		'{0, 0, -32768, 0, 0, 0, 1'b0, 0, 0},
		'{0, 0, 0, -32768, 0, 0, 1'b0, 0, 0},
		'{0, 0, 0, 0, -32768, 0, 1'b0, 0, 0},
		'{0, 0, 0, 0, 0, -32768, 1'b0, 0, 0},
		'{21845, -21846, -21846, 21845, 21845, 21845, 1'b0, 0, 0},
		'{32767, -32768, -32768, 32767, 32767, 32767, 1'b0, 0, 0},
		'{-1, -1, 0, 0, -1, 0, 1'b0, 0, 0},
		'{-32768, 32767, 32767, -32768, 0, 0, 1'b0, 0, 0}
	};

	triangle_perimeter_area_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// bitwise integer square root, floor
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned probe;
		rem   = v;
		res   = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= res + probe) begin
				rem = rem - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned side_q8(input longint dx, input longint dy);
		longint unsigned d2;
		d2 = longint'(dx * dx + dy * dy);
		return floor_root(d2 << (2 * FRAC_BITS));
	endfunction

	function automatic tri_result_t predict_triangle(input coords_t c);
		longint ax, ay, bx, by_v, cx, cy;
		longint xprod;
		longint unsigned perim;
		tri_result_t r;
		ax    = c.ax;
		ay    = c.ay;
		bx    = c.bx;
		by_v  = c.by_coord;
		cx    = c.cx;
		cy    = c.cy;
		perim = side_q8(ax - bx, ay - by_v) + side_q8(bx - cx, by_v - cy)
			+ side_q8(cx - ax, cy - ay);
		xprod = (bx - ax) * (cy - ay) - (by_v - ay) * (cx - ax);
		if (xprod < 0)
			xprod = -xprod;
		r.perim = perim[PERIM_W-1:0];
		r.area  = xprod[AREA_W-1:0];
		return r;
	endfunction

	function automatic coords_t make_coords(input int ax, input int ay, input int bx,
			input int by_v, input int cx, input int cy);
		coords_t c;
		c.ax       = ax[COORD_BITS-1:0];
		c.ay       = ay[COORD_BITS-1:0];
		c.bx       = bx[COORD_BITS-1:0];
		c.by_coord = by_v[COORD_BITS-1:0];
		c.cx       = cx[COORD_BITS-1:0];
		c.cy       = cy[COORD_BITS-1:0];
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic int pick_extreme();
		int r;
		r = $urandom_range(0, 6);
		case (r)
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	function automatic coords_t random_triangle();
		int mode;
		int bx0, by0, dx, dy, k1, k2;
		int v [6];
		mode = $urandom_range(0, 9);
		if (mode <= 3) begin
			foreach (v[j])
				v[j] = int'($signed(16'($urandom())));
		end else if (mode <= 5) begin
			// small triangle somewhere on the plane
			bx0 = $urandom_range(0, 60000) - 30000;
			by0 = $urandom_range(0, 60000) - 30000;
			foreach (v[j])
				v[j] = ((j % 2) ? by0 : bx0) + $urandom_range(0, 2000) - 1000;
		end else if (mode == 6) begin
			// collinear vertices
			bx0 = $urandom_range(0, 20000) - 10000;
			by0 = $urandom_range(0, 20000) - 10000;
			dx  = $urandom_range(0, 200) - 100;
			dy  = $urandom_range(0, 200) - 100;
			k1  = $urandom_range(0, 100) - 50;
			k2  = $urandom_range(0, 100) - 50;
			v = '{bx0, by0, bx0 + k1 * dx, by0 + k1 * dy, bx0 + k2 * dx, by0 + k2 * dy};
		end else if (mode == 7) begin
			// two coincident vertices
			foreach (v[j])
				v[j] = int'($signed(16'($urandom())));
			k1 = $urandom_range(0, 2);
			k2 = (k1 + 1) % 3;
			v[2*k2]   = v[2*k1];
			v[2*k2+1] = v[2*k1+1];
		end else if (mode == 8) begin
			foreach (v[j])
				v[j] = pick_extreme();
		end else begin
			// axis-aligned right triangle
			foreach (v[j])
				v[j] = int'($signed(16'($urandom())));
			v[3] = v[1];
			v[4] = v[0];
		end
		return make_coords(v[0], v[1], v[2], v[3], v[4], v[5]);
	endfunction

	task automatic offer_triangle(input coords_t c, input bit known, input tri_result_t known_res);
		int gap;
		s_axis_tdata  <= c;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(known ? known_res : predict_triangle(c));
		accepted_cnt++;
		gap = pick_gap();
		// quiet bands and the backpressure window keep the input saturated
		if (((accepted_cnt / 100) % 4) == 3)
			gap = 0;
		if (accepted_cnt >= PRESS_AT && accepted_cnt < 2 * PRESS_AT)
			gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		coords_t     c;
		tri_result_t known_res;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			c = make_coords(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].bx,
				directed_rows[i].by_c, directed_rows[i].cx, directed_rows[i].cy);
			known_res.perim = directed_rows[i].perim[PERIM_W-1:0];
			known_res.area  = directed_rows[i].area;
			offer_triangle(c, directed_rows[i].known, known_res);
		end
		for (int i = 0; i < N_RANDOM; i++)
			offer_triangle(random_triangle(), 1'b0, '0);
		s_axis_tvalid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (CORE_LAT + 10) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_triangle_perimeter_area_top: done, clean");
		else
			$display("tb_triangle_perimeter_area_top: done, errors");
		$finish;
	end

	// output side: random stalls, quiet bands and one long hold-off
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			ready_cyc++;
			if (!press_done && accepted_cnt >= PRESS_AT) begin
				press_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (PRESS_LEN) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (ready_stall > 0) begin
				m_axis_tready <= 1'b0;
				ready_stall--;
			end else if (((ready_cyc / 200) % 3) == 2) begin
				m_axis_tready <= 1'b1;
			end else begin
				ready_stall = pick_gap();
				m_axis_tready <= (ready_stall == 0);
				if (ready_stall > 0)
					ready_stall--;
			end
		end
	end

	always @(posedge clk) begin
		tri_result_t want;
		tri_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.perim = m_axis_tdata[PERIM_W-1:0];
			got.area  = m_axis_tdata[PERIM_W +: AREA_W];
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected beat, perimeter %0d area %0d",
					$time, got.perim, got.area);
				err_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (got.perim !== want.perim) begin
					$display("%0t: perimeter_q8 expected %0d got %0d",
						$time, want.perim, got.perim);
					err_cnt++;
				end
				if (got.area !== want.area) begin
					$display("%0t: double_area expected %0d got %0d",
						$time, want.area, got.area);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("tb_triangle_perimeter_area_top: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
design/tpa_pkg.sv
design/tpa_front.sv
design/tpa_sqrt.sv
design/triangle_perimeter_area_top.sv
test/tb_triangle_perimeter_area_top.sv
